/* hw/rtl/ssort_pkg.sv */
// shared constants and types of the selection sort engine
package ssort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;

endpackage

/* hw/rtl/ssort_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module ssort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* hw/rtl/selection_sort_engine.sv */
// selection sort engine: load, in-place selection sort over a ram, ordered emit
// Values are loaded one per cycle while o_ready is high; the transaction with
// i_is_last set starts the sort over the n stored values (at most MAX_ITEMS,
// extra values are dropped and flagged on every result). The sort walks the
// store through the single ram read port: for each position p up to n-2 it scans
// p to n-1 for the smallest value, then swaps it into p with two ram writes.
// The results then leave in order (a single value skips the sort). The block
// takes no input from the last load until the final result is taken.
module selection_sort_engine
    import ssort_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic signed [31:0] i_value,
    input  logic              i_is_last,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [31:0] o_sorted_value,
    output logic              o_is_final,
    output logic              o_overflowed
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_SWAP_A,
        S_SWAP_B,
        S_EMIT_RD,
        S_EMIT_CAP,
        S_EMIT_OUT
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    logic   r_ovf, n_ovf;
    t_idx   r_pos, n_pos;
    t_cnt   r_scan, n_scan;
    t_idx   r_ridx, n_ridx;
    logic   r_pend, n_pend;
    logic   r_first, n_first;
    t_idx   r_best_idx, n_best_idx;
    t_data  r_best_val, n_best_val;
    t_data  r_pos_val, n_pos_val;
    t_idx   r_k, n_k;
    t_data  r_out_val, n_out_val;
    logic   r_out_final, n_out_final;
    logic   r_out_ovf, n_out_ovf;

    logic  ram_we;
    t_idx  ram_waddr;
    t_data ram_wdata;
    t_idx  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    t_data rd_val;
    t_cnt  cnt_after;

    assign rd_val = t_data'(ram_rdata);

    ssort_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_ITEMS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_pos       = r_pos;
        n_scan      = r_scan;
        n_ridx      = r_ridx;
        n_pend      = r_pend;
        n_first     = r_first;
        n_best_idx  = r_best_idx;
        n_best_val  = r_best_val;
        n_pos_val   = r_pos_val;
        n_k         = r_k;
        n_out_val   = r_out_val;
        n_out_final = r_out_final;
        n_out_ovf   = r_out_ovf;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_best_val;
        ram_raddr   = r_k;
        cnt_after   = r_count;

        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (r_count < t_cnt'(MAX_ITEMS)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[IDX_W-1:0];
                        ram_wdata = i_value;
                        cnt_after = r_count + t_cnt'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_count = cnt_after;
                    if (i_is_last) begin
                        n_k = '0;
                        if (cnt_after == t_cnt'(1)) begin
                            n_state = S_EMIT_RD;
                        end else begin
                            n_pos   = '0;
                            n_scan  = '0;
                            n_pend  = 1'b0;
                            n_first = 1'b1;
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                // rdata belongs to the address issued in the previous cycle
                if (r_pend) begin
                    if (r_first) begin
                        n_best_val = rd_val;
                        n_pos_val  = rd_val;
                        n_best_idx = r_ridx;
                        n_first    = 1'b0;
                    end else if (rd_val < r_best_val) begin
                        n_best_val = rd_val;
                        n_best_idx = r_ridx;
                    end
                end
                if (r_scan < r_count) begin
                    ram_raddr = r_scan[IDX_W-1:0];
                    n_ridx    = r_scan[IDX_W-1:0];
                    n_scan    = r_scan + t_cnt'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_SWAP_A;
                    end
                end
            end
            S_SWAP_A: begin
                ram_we    = 1'b1;
                ram_waddr = r_best_idx;
                ram_wdata = r_pos_val;
                n_state   = S_SWAP_B;
            end
            S_SWAP_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = r_best_val;
                // the last position needs no pass of its own
                if (t_cnt'(r_pos) + t_cnt'(2) == r_count) begin
                    n_k     = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_pos   = r_pos + t_idx'(1);
                    n_scan  = t_cnt'(r_pos) + t_cnt'(1);
                    n_pend  = 1'b0;
                    n_first = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_EMIT_RD: begin
                ram_raddr = r_k;
                n_state   = S_EMIT_CAP;
            end
            S_EMIT_CAP: begin
                n_out_val   = rd_val;
                n_out_final = (t_cnt'(r_k) == r_count - t_cnt'(1));
                n_out_ovf   = r_ovf;
                n_state     = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (i_ready) begin
                    if (r_out_final) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + t_idx'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_pend  <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_pend  <= n_pend;
            r_first <= n_first;
        end
        r_pos       <= n_pos;
        r_scan      <= n_scan;
        r_ridx      <= n_ridx;
        r_best_idx  <= n_best_idx;
        r_best_val  <= n_best_val;
        r_pos_val   <= n_pos_val;
        r_k         <= n_k;
        r_out_val   <= n_out_val;
        r_out_final <= n_out_final;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_ready        = (r_state == S_LOAD);
    assign o_valid        = (r_state == S_EMIT_OUT);
    assign o_sorted_value = r_out_val;
    assign o_is_final     = r_out_final;
    assign o_overflowed   = r_out_ovf;

endmodule

/* hw/rtl/ssort_chk.sv */
// port-level checker for the selection sort engine, bound to the top level
module ssort_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               i_is_last,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_sorted_value,
    input logic               o_is_final,
    input logic               o_overflowed
);

    logic               r_have_prev;
    logic signed [31:0] r_prev_val;
    logic               r_prev_ovf;

    // remember the previous result of the current array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_have_prev <= !o_is_final;
        end
        if (o_valid && i_ready) begin
            r_prev_val <= o_sorted_value;
            r_prev_ovf <= o_overflowed;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sorted_value)
                               && $stable(o_is_final))
        else $error("result changed while stalled");

    a_no_load_during_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while results pending");

    a_last_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_is_last |=> !o_ready)
        else $error("input taken after last transaction");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_have_prev |-> o_sorted_value >= r_prev_val)
        else $error("results out of order");

    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_have_prev |-> o_overflowed == r_prev_ovf)
        else $error("overflow flag changed within an array");

endmodule

bind selection_sort_engine ssort_chk u_ssort_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_is_last     (i_is_last),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_sorted_value(o_sorted_value),
    .o_is_final    (o_is_final),
    .o_overflowed  (o_overflowed)
);
